### rtl/facr_pkg.sv
// ----------------------------------------------------------------------------
// facr_pkg
// Shared types and constants of the fully associative cache lookup block:
// controller/datapath command and status structs, LFSR constants, widths.
// ----------------------------------------------------------------------------
package facr_pkg;

    // fixed widths of the result fields
    localparam int CNT_W     = 32;
    localparam int WAY_OUT_W = 2;
    localparam int LFSR_W    = 16;

    // parameter defaults
    localparam int NUM_WAYS_DEF    = 4;
    localparam int BLOCK_BYTES_DEF = 4;
    localparam int ADDR_WIDTH_DEF  = 32;

    // replacement lfsr: galois, right shift
    localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS    = 16'hB400;
    localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;

    // controller to datapath commands
    typedef struct packed {
        logic start;    // latch the address and the lfsr, start tag/victim division
        logic lookup;   // compare, update store and counters, load result
    } facr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done; // tag and victim index are ready
    } facr_status_t;

    // one step of the replacement lfsr
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

### rtl/facr_cdiv.sv
// ----------------------------------------------------------------------------
// facr_cdiv
// Division by a constant. A power-of-two divisor is a shift and a mask;
// any other divisor takes one 16-bit digit per cycle through a reciprocal
// multiplication, most significant digit first.
// ----------------------------------------------------------------------------
module facr_cdiv #(
    parameter int DW      = 32,
    parameter int DIVISOR = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [DW-1:0]                    dividend,
    output logic [DW-1:0]                    quot,
    output logic [$clog2(DIVISOR+1)-1:0]     rem,
    output logic                             done
);

    localparam int  RW       = $clog2(DIVISOR + 1);
    localparam bit  IS_POW2  = ((DIVISOR & (DIVISOR - 1)) == 0);
    localparam int  SHIFT    = $clog2(DIVISOR);

    generate
        if (IS_POW2) begin : g_shift
            logic [DW-1:0] dividend_reg;

            // capture operand, result is a shift and a mask
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dividend_reg <= '0;
                end else if (start) begin
                    dividend_reg <= dividend;
                end
            end

            assign quot = dividend_reg >> SHIFT;
            assign rem  = RW'(dividend_reg & DW'(DIVISOR - 1));
            assign done = 1'b1;

        end else begin : g_recip
            localparam int DIG  = 16;
            localparam int NDIG = (DW + DIG - 1) / DIG;
            localparam int PW   = NDIG * DIG;
            localparam int XW   = RW + DIG;
            localparam int LW   = $clog2(DIVISOR);
            localparam int MW   = XW + 1;
            localparam int PRW  = XW + MW;
            localparam int CW   = $clog2(NDIG + 1);
            // rounded-up reciprocal, exact for every XW-bit numerator
            localparam longint unsigned RECIP =
                ((64'd1 << (XW + LW)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

            logic [PW-1:0]  num_reg,  num_next;
            logic [PW-1:0]  quo_reg,  quo_next;
            logic [RW-1:0]  rem_reg,  rem_next;
            logic [CW-1:0]  cnt_reg,  cnt_next;
            logic           busy_reg, busy_next;
            logic [XW-1:0]  chunk;
            logic [PRW-1:0] prod;
            logic [DIG-1:0] qdig;

            // one digit step: remainder and next digit, quotient by reciprocal
            always_comb begin
                num_next  = num_reg;
                quo_next  = quo_reg;
                rem_next  = rem_reg;
                cnt_next  = cnt_reg;
                busy_next = busy_reg;
                chunk     = {rem_reg, num_reg[PW-1 -: DIG]};
                prod      = PRW'(chunk) * PRW'(RECIP);
                qdig      = prod[XW + LW +: DIG];
                if (start) begin
                    num_next  = PW'(dividend);
                    quo_next  = '0;
                    rem_next  = '0;
                    cnt_next  = CW'(NDIG);
                    busy_next = 1'b1;
                end else if (busy_reg) begin
                    num_next = num_reg << DIG;
                    quo_next = (quo_reg << DIG) | PW'(qdig);
                    rem_next = RW'(chunk - XW'(qdig) * XW'(DIVISOR));
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        busy_next = 1'b0;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end else begin
                    busy_reg <= busy_next;
                    cnt_reg  <= cnt_next;
                end
                num_reg <= num_next;
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end

            assign quot = quo_reg[DW-1:0];
            assign rem  = rem_reg;
            assign done = !busy_reg;
        end
    endgenerate

endmodule

### rtl/facr_datapath.sv
// ----------------------------------------------------------------------------
// facr_datapath
// Tag store with valid bits, tag compare and way selection, replacement
// lfsr, saturating hit/miss counters and the result register.
// ----------------------------------------------------------------------------
module facr_datapath #(
    parameter int NUM_WAYS    = facr_pkg::NUM_WAYS_DEF,
    parameter int BLOCK_BYTES = facr_pkg::BLOCK_BYTES_DEF,
    parameter int ADDR_WIDTH  = facr_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  facr_pkg::facr_cmd_t               cmd,
    output facr_pkg::facr_status_t            status,
    input  logic [ADDR_WIDTH-1:0]             s_byte_address,
    input  logic                              cfg_wr_en,
    input  logic [facr_pkg::LFSR_W-1:0]       cfg_wr_data,
    output logic                              m_hit,
    output logic [facr_pkg::WAY_OUT_W-1:0]    m_way_used,
    output logic [facr_pkg::CNT_W-1:0]        m_hits_so_far,
    output logic [facr_pkg::CNT_W-1:0]        m_misses_so_far
);
    import facr_pkg::*;

    localparam int WAYW = $clog2(NUM_WAYS);
    localparam int TW   = ADDR_WIDTH - ($clog2(BLOCK_BYTES + 1) - 1);
    localparam int VRW  = $clog2(NUM_WAYS + 1);

    logic [TW-1:0]         tag_store [NUM_WAYS];
    logic [NUM_WAYS-1:0]   valid_reg,  valid_next;
    logic [LFSR_W-1:0]     lfsr_reg,   lfsr_next_val;
    logic [CNT_W-1:0]      hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]      miss_cnt_reg, miss_cnt_next;
    logic                  hit_reg;
    logic [WAY_OUT_W-1:0]  way_reg;

    logic [ADDR_WIDTH-1:0] tag_quot;
    logic [VRW-1:0]        vic_rem;
    logic                  tag_done, vic_done;
    logic [TW-1:0]         tag;

    logic [NUM_WAYS-1:0]   match;
    logic                  hit_any, free_any;
    logic [WAYW-1:0]       hit_way, free_way, sel_way;
    logic [WAYW+1:0]       way_wide;

    // tag = address / block size
    facr_cdiv #(
        .DW      (ADDR_WIDTH),
        .DIVISOR (BLOCK_BYTES)
    ) u_tag_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start),
        .dividend (s_byte_address),
        .quot     (tag_quot),
        .rem      (),
        .done     (tag_done)
    );

    // victim = lfsr mod number of ways
    facr_cdiv #(
        .DW      (LFSR_W),
        .DIVISOR (NUM_WAYS)
    ) u_vic_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start),
        .dividend (lfsr_reg),
        .quot     (),
        .rem      (vic_rem),
        .done     (vic_done)
    );

    assign tag             = tag_quot[TW-1:0];
    assign status.div_done = tag_done && vic_done;

    // compare against every way, lowest hit and lowest free way win
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = valid_reg[w] && (tag_store[w] == tag);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_any = 1'b1;
                hit_way = WAYW'(w);
            end
            if (!valid_reg[w]) begin
                free_any = 1'b1;
                free_way = WAYW'(w);
            end
        end
    end

    // way reported and, on a miss, written
    always_comb begin
        if (hit_any) begin
            sel_way = hit_way;
        end else if (free_any) begin
            sel_way = free_way;
        end else begin
            sel_way = vic_rem[WAYW-1:0];
        end
        way_wide = (WAYW+2)'(sel_way);
    end

    // next state of valid bits, lfsr and counters
    always_comb begin
        valid_next    = valid_reg;
        lfsr_next_val = lfsr_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (cfg_wr_en) begin
            lfsr_next_val = (cfg_wr_data == '0) ? SEED_DEFAULT : cfg_wr_data;
        end
        if (cmd.lookup) begin
            if (hit_any) begin
                if (hit_cnt_reg != COUNT_MAX) begin
                    hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                end
            end else begin
                if (miss_cnt_reg != COUNT_MAX) begin
                    miss_cnt_next = miss_cnt_reg + CNT_W'(1);
                end
                valid_next[sel_way] = 1'b1;
                if (!free_any) begin
                    lfsr_next_val = lfsr_next(lfsr_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            lfsr_reg     <= SEED_DEFAULT;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            valid_reg    <= valid_next;
            lfsr_reg     <= lfsr_next_val;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // tag fill and result register
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            if (!hit_any) begin
                tag_store[sel_way] <= tag;
            end
            hit_reg <= hit_any;
            way_reg <= way_wide[WAY_OUT_W-1:0];
        end
    end

    assign m_hit           = hit_reg;
    assign m_way_used      = way_reg;
    assign m_hits_so_far   = hit_cnt_reg;
    assign m_misses_so_far = miss_cnt_reg;

endmodule

### rtl/facr_ctrl.sv
// ----------------------------------------------------------------------------
// facr_ctrl
// Sequencer: accepts one transaction, waits for the tag and victim index,
// runs the lookup when the result register is free, drives output valid.
// ----------------------------------------------------------------------------
module facr_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output facr_pkg::facr_cmd_t     cmd,
    input  facr_pkg::facr_status_t  status
);
    import facr_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // commands and next state
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.start    = 1'b0;
        cmd.lookup   = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (status.div_done && out_free) begin
                    cmd.lookup   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/fully_assoc_cache_random_replace.sv
// Fully associative tag cache with random replacement. Each transaction on
// the s_ side carries a byte address; one result per transaction comes out
// on the m_ side with the hit flag, the way used and the saturating hit and
// miss counts including that access. A transaction is taken while the block
// is idle. With power-of-two BLOCK_BYTES and NUM_WAYS the lookup runs in the
// work state after acceptance, once the result register is free, and loads
// the result before the block returns to idle to take a new transaction. A
// BLOCK_BYTES that is not a power of two runs the tag through a divider that
// handles one 16-bit digit per cycle (ADDR_WIDTH/16 digits, rounded up), and
// a NUM_WAYS that is not a power of two runs the 16-bit LFSR through one such
// digit step for the victim index; the lookup waits until both are done. A
// result that has not been taken holds back the next lookup, so one further
// transaction is accepted and the input stays blocked until the result is taken.
// Writing cfg_wr_data loads the replacement LFSR (zero loads the default
// seed 0xACE1); write it only while the block is idle.
// ----------------------------------------------------------------------------
// fully_assoc_cache_random_replace
// Top level: controller and datapath of the fully associative tag lookup.
// ----------------------------------------------------------------------------
module fully_assoc_cache_random_replace #(
    parameter int NUM_WAYS    = facr_pkg::NUM_WAYS_DEF,
    parameter int BLOCK_BYTES = facr_pkg::BLOCK_BYTES_DEF,
    parameter int ADDR_WIDTH  = facr_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ADDR_WIDTH-1:0]             s_byte_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [facr_pkg::WAY_OUT_W-1:0]    m_way_used,
    output logic [facr_pkg::CNT_W-1:0]        m_hits_so_far,
    output logic [facr_pkg::CNT_W-1:0]        m_misses_so_far,
    input  logic                              cfg_wr_en,
    input  logic [facr_pkg::LFSR_W-1:0]       cfg_wr_data
);
    import facr_pkg::*;

    facr_cmd_t    cmd;
    facr_status_t status;

    // sequencer
    facr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // tag store, lfsr, counters, result
    facr_datapath #(
        .NUM_WAYS    (NUM_WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_byte_address  (s_byte_address),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_hit           (m_hit),
        .m_way_used      (m_way_used),
        .m_hits_so_far   (m_hits_so_far),
        .m_misses_so_far (m_misses_so_far)
    );

endmodule
